// File: hw/rtl/slsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slsm_pkg
// Shared types and constants for the sorted-list set merge engine.
// ----------------------------------------------------------------------------
package slsm_pkg;

    localparam int SLSM_LIST_DEPTH = 32;
    localparam int SLSM_VALUE_W    = 32;

    typedef enum logic [1:0] {
        KIND_LOAD_A = 2'd0,
        KIND_LOAD_B = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_RUN    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OP_MERGE = 2'd0,
        OP_UNION = 2'd1,
        OP_INTER = 2'd2,
        OP_DIFF  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_STEP
    } t_state;

    typedef struct packed {
        t_kind                            kind;
        logic signed [SLSM_VALUE_W-1:0]   value;
        t_op                              operation;
    } t_in_word;

    typedef struct packed {
        logic signed [SLSM_VALUE_W-1:0]   result_value;
        logic                             is_last;
        logic                             is_empty;
    } t_out_word;

endpackage
`default_nettype wire

// File: hw/rtl/slsm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slsm_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/sorted_list_set_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_set_merge
// Two-list merge / union / intersection / difference engine.
// ----------------------------------------------------------------------------
// Load and clear words are taken one per cycle while idle. A run word walks
// lists A and B with two cursors; each step reads both RAMs (ST_READ), then
// compares and advances through the shared signed comparator (ST_STEP),
// waiting there while a result is blocked by the output stall. Input is
// stalled for the whole run. Results leave through one output register; the
// last word of a run carries is_last, and an empty answer gives one word with
// is_empty set and a zero value. One result is held back in a pending
// register until the next one is found, which is how is_last is known. Lists
// stay intact after a run; a clear word empties both.
// ----------------------------------------------------------------------------
module sorted_list_set_merge
    import slsm_pkg::*;
#(
    parameter int LIST_DEPTH = SLSM_LIST_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_in_word  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output t_out_word      o_out_data,
    input  wire logic      i_out_stall
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    t_state                  r_state, n_state;
    t_op                     r_op, n_op;
    logic [CW-1:0]           r_cnt_a, n_cnt_a;
    logic [CW-1:0]           r_cnt_b, n_cnt_b;
    logic [CW-1:0]           r_i, n_i;
    logic [CW-1:0]           r_j, n_j;
    logic                    r_pend_valid, n_pend_valid;
    logic [SLSM_VALUE_W-1:0] r_pend_val, n_pend_val;
    logic                    r_out_valid, n_out_valid;
    t_out_word               r_out, n_out;

    logic                    in_accept;
    logic                    wr_a, wr_b, rd_en;
    logic [SLSM_VALUE_W-1:0] ram_a, ram_b;

    // step decode
    logic                    have_a, have_b, a_lt_b, b_lt_a;
    logic                    emit, adv_i, adv_j, done;
    logic [SLSM_VALUE_W-1:0] step_val;
    logic                    out_free, need_out, go, push;

    assign in_accept = i_in_valid && !o_in_stall;
    assign wr_a = in_accept && (i_in_data.kind == KIND_LOAD_A)
                  && (r_cnt_a < CW'(LIST_DEPTH));
    assign wr_b = in_accept && (i_in_data.kind == KIND_LOAD_B)
                  && (r_cnt_b < CW'(LIST_DEPTH));
    assign rd_en = (r_state == ST_READ);

    slsm_ram #(.WIDTH(SLSM_VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (wr_a),
        .i_wr_addr (r_cnt_a[AW-1:0]),
        .i_wr_data (i_in_data.value),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_i[AW-1:0]),
        .o_rd_data (ram_a)
    );

    slsm_ram #(.WIDTH(SLSM_VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (wr_b),
        .i_wr_addr (r_cnt_b[AW-1:0]),
        .i_wr_data (i_in_data.value),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_j[AW-1:0]),
        .o_rd_data (ram_b)
    );

    // one step of the cursor walk
    always_comb begin
        have_a   = (r_i < r_cnt_a);
        have_b   = (r_j < r_cnt_b);
        a_lt_b   = ($signed(ram_a) < $signed(ram_b));
        b_lt_a   = !a_lt_b && (ram_a != ram_b);
        emit     = 1'b0;
        adv_i    = 1'b0;
        adv_j    = 1'b0;
        done     = 1'b0;
        step_val = ram_a;
        if (have_a && have_b) begin
            if (r_op == OP_MERGE) begin
                emit = 1'b1;
                if (a_lt_b) begin
                    adv_i = 1'b1;
                end else begin
                    step_val = ram_b;
                    adv_j    = 1'b1;
                end
            end else if (a_lt_b) begin
                emit  = (r_op != OP_INTER);
                adv_i = 1'b1;
            end else if (b_lt_a) begin
                emit     = (r_op == OP_UNION);
                step_val = ram_b;
                adv_j    = 1'b1;
            end else begin
                emit  = (r_op == OP_UNION) || (r_op == OP_INTER);
                adv_i = 1'b1;
                adv_j = 1'b1;
            end
        end else if (have_a && (r_op != OP_INTER)) begin
            emit  = 1'b1;
            adv_i = 1'b1;
        end else if (have_b && ((r_op == OP_MERGE) || (r_op == OP_UNION))) begin
            emit     = 1'b1;
            step_val = ram_b;
            adv_j    = 1'b1;
        end else begin
            done = 1'b1;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign need_out = done || (emit && r_pend_valid);
    assign go       = (r_state == ST_STEP) && (!need_out || out_free);
    assign push     = go && need_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && (i_in_data.kind == KIND_RUN)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_STEP;
            end
            ST_STEP: begin
                if (go) begin
                    n_state = done ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_op         = r_op;
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_i          = r_i;
        n_j          = r_j;
        n_pend_valid = r_pend_valid;
        n_pend_val   = r_pend_val;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;

        if (wr_a) begin
            n_cnt_a = r_cnt_a + CW'(1);
        end
        if (wr_b) begin
            n_cnt_b = r_cnt_b + CW'(1);
        end
        if (in_accept && (i_in_data.kind == KIND_CLEAR)) begin
            n_cnt_a = '0;
            n_cnt_b = '0;
        end
        if (in_accept && (i_in_data.kind == KIND_RUN)) begin
            n_op         = i_in_data.operation;
            n_i          = '0;
            n_j          = '0;
            n_pend_valid = 1'b0;
        end

        if (go) begin
            if (adv_i) begin
                n_i = r_i + CW'(1);
            end
            if (adv_j) begin
                n_j = r_j + CW'(1);
            end
            if (emit) begin
                n_pend_valid = 1'b1;
                n_pend_val   = step_val;
            end
            if (done) begin
                n_pend_valid = 1'b0;
            end
        end

        if (push) begin
            n_out_valid = 1'b1;
            if (done && !r_pend_valid) begin
                n_out.result_value = '0;
                n_out.is_last      = 1'b1;
                n_out.is_empty     = 1'b1;
            end else begin
                n_out.result_value = r_pend_val;
                n_out.is_last      = done;
                n_out.is_empty     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt_a      <= n_cnt_a;
            r_cnt_b      <= n_cnt_b;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_i        <= n_i;
        r_j        <= n_j;
        r_pend_val <= n_pend_val;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CW'(LIST_DEPTH)) && (r_cnt_b <= CW'(LIST_DEPTH)))
        else $error("list count above depth");

    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP) |-> ((r_i <= r_cnt_a) && (r_j <= r_cnt_b)))
        else $error("cursor past list end");

    a_out_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_STEP))
        else $error("result word raised outside a walk step");

    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("pending result left after run");

endmodule
`default_nettype wire
